// ===== sv/rwsi_pkg.sv =====
// Shared types and constants for the ray / wall segment intersection counter.
// Depends on nothing; every other file imports it.
package rwsi_pkg;

  localparam int COORD_W   = 16;                 // signed Q8.8 coordinate
  localparam int DIFF_W    = COORD_W + 1;        // exact coordinate difference
  localparam int CROSS_W   = 2 * DIFF_W + 1;     // exact 2D cross product
  localparam int MAG_W     = CROSS_W;            // magnitude of a cross product
  localparam int QUO_W     = COORD_W;            // quotient magnitude bound
  localparam int PROD_W    = MAG_W + QUO_W;      // |tn| * |delta|
  localparam int REM_W     = MAG_W + 1;          // divider partial remainder
  localparam int CNT_W     = 11;
  localparam int MAX_WALLS = 1024;
  localparam int HIT_LIMIT = (MAX_WALLS > 2047) ? 2047 : MAX_WALLS;
  localparam int CFG_IDX_W = 3;
  localparam int DIV_STEPS = QUO_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RAY_START_X,
    CFG_RAY_START_Y,
    CFG_RAY_START_Z,
    CFG_RAY_END_X,
    CFG_RAY_END_Y,
    CFG_RAY_END_Z
  } cfg_reg_t;

  typedef enum logic [1:0] {
    XSEL_D,
    XSEL_T,
    XSEL_U
  } cross_sel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CROSS_D,
    S_CROSS_T,
    S_CROSS_U,
    S_TEST,
    S_MULT,
    S_DIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic                      last;
  } wall_t;

  typedef struct packed {
    logic                      hit;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic [CNT_W-1:0]          hits_so_far;
    logic                      last_result;
  } result_t;

  typedef struct packed {
    logic       load_wall;
    logic       cross_en;
    cross_sel_t cross_sel;
    logic       test;
    logic       div_load;
    logic       div_step;
    logic       publish;
  } dp_cmd_t;

  typedef struct packed {
    logic hit_now;
  } dp_status_t;

endpackage

// ===== sv/rwsi_if.sv =====
// Valid/ready channel interfaces for wall transactions and result transactions.
// Depends on rwsi_pkg for the coordinate and count widths.
interface rwsi_in_if import rwsi_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] wall_start_x;
  logic signed [COORD_W-1:0] wall_start_y;
  logic signed [COORD_W-1:0] wall_end_x;
  logic signed [COORD_W-1:0] wall_end_y;
  logic                      last_wall;

  modport source (output valid, wall_start_x, wall_start_y, wall_end_x, wall_end_y,
                  last_wall, input ready);
  modport sink (input valid, wall_start_x, wall_start_y, wall_end_x, wall_end_y,
                last_wall, output ready);
endinterface

interface rwsi_out_if import rwsi_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      hit;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic signed [COORD_W-1:0] point_z;
  logic [CNT_W-1:0]          hits_so_far;
  logic                      last_result;

  modport source (output valid, hit, point_x, point_y, point_z, hits_so_far,
                  last_result, input ready);
  modport sink (input valid, hit, point_x, point_y, point_z, hits_so_far,
                last_result, output ready);
endinterface

// ===== sv/rwsi_div.sv =====
// Radix-2 restoring divider lane: |tn|*|delta| / |d|, one bit a cycle on step.
// Depends on rwsi_pkg.
module rwsi_div import rwsi_pkg::*; (
  input  logic              clk,
  input  logic              load,
  input  logic              step,
  input  logic [PROD_W-1:0] dividend,
  input  logic [MAG_W-1:0]  divisor,
  output logic [QUO_W-1:0]  quotient
);

  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [QUO_W-1:0] lo_r, lo_nxt;
  logic [REM_W-1:0] trial;
  logic [REM_W-1:0] dvs;
  logic             ge;

  // Dividend < divisor * 2^QUO_W, so the upper part starts below the divisor.
  always_comb begin
    dvs   = {1'b0, divisor};
    trial = {rem_r[REM_W-2:0], lo_r[QUO_W-1]};
    ge    = (trial >= dvs);
    rem_nxt = rem_r;
    lo_nxt  = lo_r;
    if (load) begin
      rem_nxt = {1'b0, dividend[PROD_W-1:QUO_W]};
      lo_nxt  = dividend[QUO_W-1:0];
    end else if (step) begin
      rem_nxt = ge ? (trial - dvs) : trial;
      lo_nxt  = {lo_r[QUO_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    lo_r  <= lo_nxt;
  end

  assign quotient = lo_r;

endmodule

// ===== sv/rwsi_ctrl.sv =====
// Sequencer for the intersection datapath: handshakes, step order, divide count.
// Depends on rwsi_pkg.
module rwsi_ctrl import rwsi_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t               state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.cross_sel = XSEL_D;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_wall = 1'b1;
          state_nxt     = S_CROSS_D;
        end
      end
      S_CROSS_D: begin
        cmd.cross_en  = 1'b1;
        cmd.cross_sel = XSEL_D;
        state_nxt     = S_CROSS_T;
      end
      S_CROSS_T: begin
        cmd.cross_en  = 1'b1;
        cmd.cross_sel = XSEL_T;
        state_nxt     = S_CROSS_U;
      end
      S_CROSS_U: begin
        cmd.cross_en  = 1'b1;
        cmd.cross_sel = XSEL_U;
        state_nxt     = S_TEST;
      end
      S_TEST: begin
        cmd.test  = 1'b1;
        state_nxt = status.hit_now ? S_MULT : S_DONE;
      end
      S_MULT: begin
        cmd.div_load = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.publish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_CROSS_D))
    else $error("accepted wall did not start the cross products");

  a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) |=> (state_r == S_DONE))
    else $error("divide did not finish after its last step");

  a_mult_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MULT) |-> ($past(state_r) == S_TEST && $past(status.hit_now)))
    else $error("divide started without a hit");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result raised outside the finish step");

endmodule

// ===== sv/rwsi_dp.sv =====
// Datapath: ray registers, cross products, hit test, three divide lanes, hit count,
// result register. Depends on rwsi_pkg and rwsi_div.
module rwsi_dp import rwsi_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_data,
  input  wall_t                in_wall,
  input  dp_cmd_t              cmd,
  output dp_status_t           status,
  output result_t              result
);

  coord_t rsx_r, rsy_r, rsz_r, rex_r, rey_r, rez_r;
  wall_t  wall_r;

  logic signed [CROSS_W-1:0] d_r, tn_r, un_r;
  logic                      hit_r;
  logic [MAG_W-1:0]          tnmag_r, dmag_r;
  logic                      qneg_r;
  logic [CNT_W-1:0]          cnt_r, cnt_after;
  result_t                   res_r;

  logic signed [DIFF_W-1:0]   rx, ry, rz, wx, wy, qx, qy;
  logic signed [DIFF_W-1:0]   op_a, op_b, op_c, op_e;
  logic signed [2*DIFF_W-1:0] prod_ab, prod_ce;
  logic signed [CROSS_W-1:0]  xprod;
  logic [QUO_W-1:0]           rxm, rym, rzm;
  logic [PROD_W-1:0]          nx, ny, nz;
  logic [QUO_W-1:0]           qx_mag, qy_mag, qz_mag;
  logic signed [DIFF_W-1:0]   sx, sy, sz;
  logic signed [DIFF_W-1:0]   px, py, pz;

  function automatic logic in_unit(logic signed [CROSS_W-1:0] num,
                                   logic signed [CROSS_W-1:0] den);
    if (den > 0) begin
      return (num >= 0) && (num <= den);
    end
    return (num <= 0) && (num >= den);
  endfunction

  function automatic logic [MAG_W-1:0] mag(logic signed [CROSS_W-1:0] v);
    return v[CROSS_W-1] ? MAG_W'(-v) : MAG_W'(v);
  endfunction

  function automatic logic [QUO_W-1:0] dmag16(logic signed [DIFF_W-1:0] v);
    logic signed [DIFF_W-1:0] n;
    n = -v;
    return v[DIFF_W-1] ? n[QUO_W-1:0] : v[QUO_W-1:0];
  endfunction

  // ray registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rsx_r <= '0;
      rsy_r <= '0;
      rsz_r <= '0;
      rex_r <= '0;
      rey_r <= '0;
      rez_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_RAY_START_X: rsx_r <= cfg_data;
        CFG_RAY_START_Y: rsy_r <= cfg_data;
        CFG_RAY_START_Z: rsz_r <= cfg_data;
        CFG_RAY_END_X:   rex_r <= cfg_data;
        CFG_RAY_END_Y:   rey_r <= cfg_data;
        CFG_RAY_END_Z:   rez_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign rx = DIFF_W'(rex_r) - DIFF_W'(rsx_r);
  assign ry = DIFF_W'(rey_r) - DIFF_W'(rsy_r);
  assign rz = DIFF_W'(rez_r) - DIFF_W'(rsz_r);
  assign wx = DIFF_W'(wall_r.end_x) - DIFF_W'(wall_r.start_x);
  assign wy = DIFF_W'(wall_r.end_y) - DIFF_W'(wall_r.start_y);
  assign qx = DIFF_W'(wall_r.start_x) - DIFF_W'(rsx_r);
  assign qy = DIFF_W'(wall_r.start_y) - DIFF_W'(rsy_r);

  // one cross product a cycle: a*b - c*e
  assign op_a = (cmd.cross_sel == XSEL_D) ? rx : qx;
  assign op_c = (cmd.cross_sel == XSEL_D) ? ry : qy;
  assign op_b = (cmd.cross_sel == XSEL_U) ? ry : wy;
  assign op_e = (cmd.cross_sel == XSEL_U) ? rx : wx;
  assign prod_ab = op_a * op_b;
  assign prod_ce = op_c * op_e;
  assign xprod   = CROSS_W'(prod_ab) - CROSS_W'(prod_ce);

  assign status.hit_now = (d_r != 0) && in_unit(tn_r, d_r) && in_unit(un_r, d_r);

  always_ff @(posedge clk) begin
    if (cmd.load_wall) begin
      wall_r <= in_wall;
    end
    if (cmd.cross_en) begin
      unique case (cmd.cross_sel)
        XSEL_D:  d_r  <= xprod;
        XSEL_T:  tn_r <= xprod;
        XSEL_U:  un_r <= xprod;
        default: ;
      endcase
    end
    if (cmd.test) begin
      tnmag_r <= mag(tn_r);
      dmag_r  <= mag(d_r);
      qneg_r  <= tn_r[CROSS_W-1] ^ d_r[CROSS_W-1];
    end
  end

  // |tn| * |delta| per axis, registered into the lanes
  assign rxm = dmag16(rx);
  assign rym = dmag16(ry);
  assign rzm = dmag16(rz);
  assign nx  = tnmag_r * rxm;
  assign ny  = tnmag_r * rym;
  assign nz  = tnmag_r * rzm;

  rwsi_div u_div_x (
    .clk      (clk),
    .load     (cmd.div_load),
    .step     (cmd.div_step),
    .dividend (nx),
    .divisor  (dmag_r),
    .quotient (qx_mag)
  );

  rwsi_div u_div_y (
    .clk      (clk),
    .load     (cmd.div_load),
    .step     (cmd.div_step),
    .dividend (ny),
    .divisor  (dmag_r),
    .quotient (qy_mag)
  );

  rwsi_div u_div_z (
    .clk      (clk),
    .load     (cmd.div_load),
    .step     (cmd.div_step),
    .dividend (nz),
    .divisor  (dmag_r),
    .quotient (qz_mag)
  );

  // sign applied after the magnitude divide: truncation toward zero
  assign sx = (qneg_r ^ rx[DIFF_W-1]) ? -DIFF_W'({1'b0, qx_mag}) : DIFF_W'({1'b0, qx_mag});
  assign sy = (qneg_r ^ ry[DIFF_W-1]) ? -DIFF_W'({1'b0, qy_mag}) : DIFF_W'({1'b0, qy_mag});
  assign sz = (qneg_r ^ rz[DIFF_W-1]) ? -DIFF_W'({1'b0, qz_mag}) : DIFF_W'({1'b0, qz_mag});
  assign px = DIFF_W'(rsx_r) + sx;
  assign py = DIFF_W'(rsy_r) + sy;
  assign pz = DIFF_W'(rsz_r) + sz;

  assign cnt_after = (hit_r && (cnt_r < CNT_W'(HIT_LIMIT))) ? (cnt_r + 1'b1) : cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
      cnt_r <= '0;
      res_r <= '0;
    end else begin
      if (cmd.test) begin
        hit_r <= status.hit_now;
      end
      if (cmd.publish) begin
        res_r.hit         <= hit_r;
        res_r.point_x     <= hit_r ? px[COORD_W-1:0] : '0;
        res_r.point_y     <= hit_r ? py[COORD_W-1:0] : '0;
        res_r.point_z     <= hit_r ? pz[COORD_W-1:0] : '0;
        res_r.hits_so_far <= cnt_after;
        res_r.last_result <= wall_r.last;
        cnt_r             <= wall_r.last ? '0 : cnt_after;
      end
    end
  end

  assign result = res_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(HIT_LIMIT))
    else $error("hit count passed its limit");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !res_r.hit |-> (res_r.point_x == 0 && res_r.point_y == 0 && res_r.point_z == 0))
    else $error("point not zero on a miss");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(cmd.publish) && res_r.last_result) |-> (cnt_r == 0))
    else $error("count not cleared after the last wall");

endmodule

// ===== sv/ray_wall_segment_intersection_counter_core.sv =====
// Top level of the ray / wall segment intersection counter.
// Depends on rwsi_pkg, rwsi_if, rwsi_ctrl, rwsi_dp (and rwsi_div below it).
//
//   channel  | dir | handshake     | transaction
//   ---------+-----+---------------+-----------------------------------------------
//   in_ch    | in  | valid / ready | one wall: start x,y, end x,y, last marker
//   out_ch   | out | valid / ready | hit, point x,y,z, hits so far, last echo
//   cfg_*    | in  | cfg_we        | ray register cfg_index <= cfg_data, no stall
//
// A wall that hits goes from acceptance to the result register through three
// cross-product steps, a test, a multiply, the divider steps (three lanes in
// parallel, one quotient bit each per cycle) and the finish step; a miss skips
// the multiply and the divider steps. Each new wall is taken in the idle step.
// One wall is worked at a time; a new wall is taken while a result waits in the
// output register, and the finish step waits only if that register is still full.
// Synchronous active-low reset clears the ray registers, the hit count and control.
module ray_wall_segment_intersection_counter_core import rwsi_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  rwsi_in_if.sink              in_ch,
  rwsi_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;
  wall_t      in_wall;
  result_t    result;
  logic       in_ready;
  logic       out_valid;

  assign in_wall.start_x = in_ch.wall_start_x;
  assign in_wall.start_y = in_ch.wall_start_y;
  assign in_wall.end_x   = in_ch.wall_end_x;
  assign in_wall.end_y   = in_ch.wall_end_y;
  assign in_wall.last    = in_ch.last_wall;
  assign in_ch.ready     = in_ready;

  // sequencer: owns the handshakes and the step order
  rwsi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // arithmetic, hit count and the result register
  rwsi_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_wall   (in_wall),
    .cmd       (cmd),
    .status    (status),
    .result    (result)
  );

  assign out_ch.valid       = out_valid;
  assign out_ch.hit         = result.hit;
  assign out_ch.point_x     = result.point_x;
  assign out_ch.point_y     = result.point_y;
  assign out_ch.point_z     = result.point_z;
  assign out_ch.hits_so_far = result.hits_so_far;
  assign out_ch.last_result = result.last_result;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the ray / wall segment intersection counter core.
// Depends on rwsi_pkg, the rwsi_if channel interfaces and the core itself.
module testbench import rwsi_pkg::*; ();

  // ---------------------------------------------------------------------------
  // Constants and types
  // ---------------------------------------------------------------------------
  localparam int CLK_HALF      = 6;     // 12 ns period
  localparam int RESET_CYCLES  = 6;
  localparam int SETTLE_CYCLES = 32;    // covers the hit path, plus margin
  localparam int LONG_HOLD     = 400;   // receiver back-pressure stretch
  localparam int CHUNK_WALLS   = 50;
  localparam int CHUNKS        = 5;
  localparam int SAT_WALLS     = MAX_WALLS + 6;
  // indexes beyond the ray registers; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_BASE = CFG_IDX_W'(CFG_RAY_END_Z) + 1'b1;

  typedef coord_t ray_set_t [6];   // ordered as the register indexes

  typedef struct {
    int               ray_idx;
    coord_t           wsx, wsy, wex, wey;
    logic             last;
    bit               typed;       // expectation written below, not predicted
    logic             hit;
    coord_t           px, py, pz;
    logic [CNT_W-1:0] tally;
  } dir_row_t;

  // ---------------------------------------------------------------------------
  // Clock, channels, DUT
  // ---------------------------------------------------------------------------
  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COORD_W-1:0]   cfg_data;

  rwsi_in_if  wall_ch ();
  rwsi_out_if res_ch ();

  ray_wall_segment_intersection_counter_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (wall_ch),
    .out_ch    (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Mirror of the ray registers and the hit tally, plus pending results
  // ---------------------------------------------------------------------------
  coord_t           ray_regs [6];
  logic [CNT_W-1:0] hit_tally;
  result_t          pending_results [$];
  int               mismatches;

  int send_gap_pct;     // sender idles in this many cycles of a hundred
  int recv_stall_pct;   // receiver stalls likewise
  int hold_req;         // bumped to ask the receiver for one long hold-off

  // Rays for the directed part: reset state, short axis ray, both diagonals at
  // the coordinate extremes.
  ray_set_t dir_rays [4] = '{
    '{0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 16'sh0200, 0, 16'sh0400},
    '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF},
    '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000}
  };

  // ray, wall sx sy ex ey, last, typed, hit, point x y z, hits so far
  dir_row_t dir_rows [20] = '{
    // zero-length ray after reset: always parallel, no hit
    '{0, 16'shFF00, 16'shFF00, 16'sh0100, 16'sh0100, 0, 1, 0, 0, 0, 0, 0},
    '{0, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 1, 1, 0, 0, 0, 0, 0},
    // ray (0,0,0) -> (2m,0,4m): crossing at the midpoint
    '{1, 16'sh0100, 16'shFF00, 16'sh0100, 16'sh0100, 0, 1, 1, 16'sh0100, 0, 16'sh0200, 1},
    // parallel, collinear overlap, zero-length wall: no hit, count held
    '{1, 16'sh0000, 16'sh0100, 16'sh0200, 16'sh0100, 0, 1, 0, 0, 0, 0, 1},
    '{1, 16'sh0080, 16'sh0000, 16'sh0180, 16'sh0000, 0, 1, 0, 0, 0, 0, 1},
    '{1, 16'sh0100, 16'sh0000, 16'sh0100, 16'sh0000, 0, 1, 0, 0, 0, 0, 1},
    // touching at the ray start, the ray end, the wall start, the wall end
    '{1, 16'sh0000, 16'shFF00, 16'sh0000, 16'sh0100, 0, 0, 0, 0, 0, 0, 0},
    '{1, 16'sh0200, 16'shFF00, 16'sh0200, 16'sh0100, 0, 0, 0, 0, 0, 0, 0},
    '{1, 16'sh0100, 16'sh0000, 16'sh0100, 16'sh0100, 0, 0, 0, 0, 0, 0, 0},
    '{1, 16'sh0100, 16'shFF00, 16'sh0100, 16'sh0000, 0, 0, 0, 0, 0, 0, 0},
    // one LSB past the ray end
    '{1, 16'sh0201, 16'shFF00, 16'sh0201, 16'sh0100, 0, 0, 0, 0, 0, 0, 0},
    // reversed wall, negative denominator; closes the set
    '{1, 16'sh0100, 16'sh0100, 16'sh0100, 16'shFF00, 1, 0, 0, 0, 0, 0, 0},
    // first wall of a fresh set: count restarts at one
    '{1, 16'sh0080, 16'shFF00, 16'sh0080, 16'sh0100, 1, 1, 1, 16'sh0080, 0, 16'sh0100, 1},
    // full-range diagonal rays
    '{2, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 0, 0, 0, 0, 0, 0, 0},
    '{2, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 0, 0, 0, 0, 0, 0, 0},
    '{2, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF, 0, 0, 0, 0, 0, 0, 0},
    '{2, 16'sh0000, 16'sh8000, 16'sh0001, 16'sh7FFF, 1, 0, 0, 0, 0, 0, 0},
    '{3, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 0, 0, 0, 0, 0, 0, 0},
    '{3, 16'sh0000, 16'sh0000, 16'sh7FFF, 16'sh7FFF, 0, 0, 0, 0, 0, 0, 0},
    '{3, 16'sh8000, 16'sh0000, 16'sh7FFF, 16'sh0001, 1, 0, 0, 0, 0, 0, 0}
  };

  // ---------------------------------------------------------------------------
  // Intersection predictor
  // ---------------------------------------------------------------------------
  function automatic bit within_unit(input longint num, input longint den);
    if (den > 0) return num >= 0 && num <= den;
    return num <= 0 && num >= den;
  endfunction

  // Exact cross products, sign-aware range test on the numerators, then the
  // point by a divide that truncates towards zero. Advances the hit tally.
  function automatic result_t predict_crossing(input wall_t w);
    longint  sx, sy, sz, rx, ry, rz, wx, wy, qx, qy, d, tn, un;
    result_t r;
    sx = longint'(ray_regs[CFG_RAY_START_X]);
    sy = longint'(ray_regs[CFG_RAY_START_Y]);
    sz = longint'(ray_regs[CFG_RAY_START_Z]);
    rx = longint'(ray_regs[CFG_RAY_END_X]) - sx;
    ry = longint'(ray_regs[CFG_RAY_END_Y]) - sy;
    rz = longint'(ray_regs[CFG_RAY_END_Z]) - sz;
    wx = longint'(w.end_x) - longint'(w.start_x);
    wy = longint'(w.end_y) - longint'(w.start_y);
    qx = longint'(w.start_x) - sx;
    qy = longint'(w.start_y) - sy;
    d  = rx * wy - ry * wx;
    tn = qx * wy - qy * wx;
    un = qx * ry - qy * rx;
    r = '0;
    if (d != 0 && within_unit(tn, d) && within_unit(un, d)) begin
      r.hit     = 1'b1;
      r.point_x = coord_t'(sx + (tn * rx) / d);
      r.point_y = coord_t'(sy + (tn * ry) / d);
      r.point_z = coord_t'(sz + (tn * rz) / d);
      if (hit_tally < HIT_LIMIT) hit_tally = hit_tally + 1'b1;
    end
    r.hits_so_far = hit_tally;
    r.last_result = w.last;
    if (w.last) hit_tally = '0;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Random stimulus shaping
  // ---------------------------------------------------------------------------
  function automatic coord_t clamp16(input longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return coord_t'(v);
  endfunction

  // signed offset, spread over magnitudes from zero up to full scale
  function automatic longint rand_offset();
    longint m;
    m = longint'($urandom_range(0, 32767) >> $urandom_range(0, 14));
    return $urandom_range(0, 1) ? m : -m;
  endfunction

  function automatic ray_set_t pick_ray();
    ray_set_t r;
    int       kind;
    kind = $urandom_range(0, 3);
    for (int i = 0; i < 6; i++) begin
      case (kind)
        0: r[i] = coord_t'($urandom);
        1: r[i] = coord_t'($urandom_range(0, 4095)) - 16'sd2048;
        2: r[i] = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        default: r[i] = coord_t'($urandom_range(0, 16383)) - 16'sd8192;
      endcase
    end
    // axis-aligned rays
    if (kind == 3) begin
      if ($urandom_range(0, 1)) r[CFG_RAY_END_X] = r[CFG_RAY_START_X];
      else r[CFG_RAY_END_Y] = r[CFG_RAY_START_Y];
    end
    return r;
  endfunction

  // Mostly walls laid across the ray so hits are common; the rest touch an
  // end point, run parallel, have zero length or are pure noise.
  function automatic wall_t gen_wall(input logic last);
    wall_t  w;
    longint sx, sy, ex, ey, f, px, py, dx, dy;
    int     pick;
    sx = longint'(ray_regs[CFG_RAY_START_X]);
    sy = longint'(ray_regs[CFG_RAY_START_Y]);
    ex = longint'(ray_regs[CFG_RAY_END_X]);
    ey = longint'(ray_regs[CFG_RAY_END_Y]);
    dx = rand_offset();
    dy = rand_offset();
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      f  = $urandom_range(0, 256);
      px = sx + (ex - sx) * f / 256;
      py = sy + (ey - sy) * f / 256;
      w.start_x = clamp16(px + dx);
      w.start_y = clamp16(py + dy);
      w.end_x   = clamp16(px - dx);
      w.end_y   = clamp16(py - dy);
    end else if (pick < 65) begin
      px = $urandom_range(0, 1) ? sx : ex;
      py = (px == sx) ? sy : ey;
      if ($urandom_range(0, 1)) begin
        w.start_x = coord_t'(px);       w.start_y = coord_t'(py);
        w.end_x   = clamp16(px + dx);   w.end_y   = clamp16(py + dy);
      end else begin
        w.start_x = clamp16(px + dx);   w.start_y = clamp16(py + dy);
        w.end_x   = coord_t'(px);       w.end_y   = coord_t'(py);
      end
    end else if (pick < 75) begin
      if ($urandom_range(0, 2) == 0) begin
        dx = 0;
        dy = 0;
      end
      w.start_x = clamp16(sx + dx);
      w.start_y = clamp16(sy + dy);
      w.end_x   = clamp16(ex + dx);
      w.end_y   = clamp16(ey + dy);
    end else if (pick < 80) begin
      w.start_x = coord_t'($urandom);
      w.start_y = coord_t'($urandom);
      w.end_x   = w.start_x;
      w.end_y   = w.start_y;
    end else begin
      w.start_x = coord_t'($urandom);
      w.start_y = coord_t'($urandom);
      w.end_x   = coord_t'($urandom);
      w.end_y   = coord_t'($urandom);
    end
    w.last = last;
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // Valid is left high after a transaction; the next call lowers it only if it
  // idles, so valid never sees two assignments in one step.
  task automatic send_wall(input wall_t w, input bit typed, input result_t typed_res);
    result_t pred;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      wall_ch.valid <= 1'b0;
      @(posedge clk);
    end
    wall_ch.valid        <= 1'b1;
    wall_ch.wall_start_x <= w.start_x;
    wall_ch.wall_start_y <= w.start_y;
    wall_ch.wall_end_x   <= w.end_x;
    wall_ch.wall_end_y   <= w.end_y;
    wall_ch.last_wall    <= w.last;
    do @(posedge clk); while (wall_ch.ready !== 1'b1);
    pred = predict_crossing(w);
    pending_results.push_back(typed ? typed_res : pred);
  endtask

  // Stop offering, let every pending result arrive, then allow the core to
  // settle before any register write.
  task automatic drain();
    wall_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Six ray registers back to back, then a junk write to an unused index.
  task automatic load_ray(input ray_set_t r);
    for (int i = CFG_RAY_START_X; i <= CFG_RAY_END_Z; i++) begin
      cfg_we      <= 1'b1;
      cfg_index   <= CFG_IDX_W'(i);
      cfg_data    <= r[i];
      ray_regs[i]  = r[i];
      @(posedge clk);
    end
    cfg_index <= CFG_SPARE_BASE + CFG_IDX_W'($urandom_range(0, 1));
    cfg_data  <= COORD_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: oldest pending result against each accepted transaction
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [15:0] expv,
                                      input logic [15:0] actv);
    if (actv !== expv) begin
      $error("%s: expected 'h%0h, got 'h%0h", name, expv, actv);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing pending");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("hit",         want.hit,         res_ch.hit);
        check_field("point_x",     want.point_x,     res_ch.point_x);
        check_field("point_y",     want.point_y,     res_ch.point_y);
        check_field("point_z",     want.point_z,     res_ch.point_z);
        check_field("hits_so_far", want.hits_so_far, res_ch.hits_so_far);
        check_field("last_result", want.last_result, res_ch.last_result);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    int       gap_tab   [4];
    int       stall_tab [4];
    int       cur_ray;
    wall_t    w;
    result_t  typed_res;
    ray_set_t sat_ray;
    longint   y_pos;
    longint   half_w;

    gap_tab   = '{0, 46, 0, 16};
    stall_tab = '{0, 0, 46, 16};
    sat_ray   = '{0, 16'shC000, 16'sh0100, 0, 16'sh4000, 16'shFF00};

    mismatches     = 0;
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    hold_req       = 0;
    hit_tally      = '0;
    for (int i = 0; i < 6; i++) ray_regs[i] = '0;

    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_index            <= '0;
    cfg_data             <= '0;
    wall_ch.valid        <= 1'b0;
    wall_ch.wall_start_x <= '0;
    wall_ch.wall_start_y <= '0;
    wall_ch.wall_end_x   <= '0;
    wall_ch.wall_end_y   <= '0;
    wall_ch.last_wall    <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table; ray 0 is the reset state and needs no write
    cur_ray = 0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].ray_idx != cur_ray) begin
        drain();
        cur_ray = dir_rows[i].ray_idx;
        load_ray(dir_rays[cur_ray]);
      end
      w.start_x = dir_rows[i].wsx;
      w.start_y = dir_rows[i].wsy;
      w.end_x   = dir_rows[i].wex;
      w.end_y   = dir_rows[i].wey;
      w.last    = dir_rows[i].last;
      typed_res = '{dir_rows[i].hit, dir_rows[i].px, dir_rows[i].py, dir_rows[i].pz,
                    dir_rows[i].tally, dir_rows[i].last};
      send_wall(w, dir_rows[i].typed, typed_res);
    end

    // random walls: four idling patterns, a fresh ray per chunk; the first
    // chunk also holds the receiver off long enough for the core to back up
    for (int p = 0; p < 4; p++) begin
      for (int c = 0; c < CHUNKS; c++) begin
        drain();
        send_gap_pct   = gap_tab[p];
        recv_stall_pct = stall_tab[p];
        load_ray(pick_ray());
        if (p == 0 && c == 0) hold_req++;
        repeat (CHUNK_WALLS) send_wall(gen_wall($urandom_range(0, 11) == 0), 1'b0, '0);
      end
    end

    // one long set of guaranteed crossings to drive the count into saturation
    drain();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    load_ray(sat_ray);
    for (int i = 0; i < SAT_WALLS; i++) begin
      y_pos  = longint'($urandom_range(0, 16'h7E00)) - 16'h3F00;
      half_w = $urandom_range(1, 32767);
      w.start_x = coord_t'(-half_w);
      w.start_y = coord_t'(y_pos);
      w.end_x   = coord_t'(half_w);
      w.end_y   = coord_t'(y_pos);
      w.last    = (i == SAT_WALLS - 1);
      send_wall(w, 1'b0, '0);
    end

    drain();
    if (mismatches == 0) begin
      $display("PASS ray_wall_segment_intersection_counter_core");
    end else begin
      $display("FAIL ray_wall_segment_intersection_counter_core");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #10_000_000;
    $display("FAIL ray_wall_segment_intersection_counter_core");
    $finish;
  end

endmodule
